@@ hdl/rilu_pkg.sv @@
// shared types and constants for the ipv4 range table lookup unit
// no dependencies; imported by rilu_scan_unit, the top unit and the bench
package rilu_pkg;

	localparam int OPCODE_W     = 2;
	localparam int SLOT_W       = 16;
	localparam int ADDR_W       = 32;
	localparam int UPPER_W      = 32;
	localparam int OFFSET_W     = 24;
	localparam int LENGTH_W     = 8;
	localparam int LIMIT_W      = 17;
	localparam int PREFIX_COUNT = 256;
	localparam int PREFIX_AW    = 8;
	localparam int ENTRY_W      = UPPER_W + OFFSET_W + LENGTH_W;

	typedef enum logic [OPCODE_W-1:0] {
		OP_WRITE_PREFIX = 2'd0,
		OP_WRITE_ENTRY  = 2'd1,
		OP_LOOKUP       = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PFX,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_addr;
		logic load_idx;
		logic step;
		logic capture;
	} scan_ctrl_t;

	typedef struct packed {
		logic in_range;
		logic hit;
	} scan_stat_t;

endpackage

@@ hdl/rilu_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module rilu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/rilu_scan_unit.sv @@
// scan datapath: entry index counter, limit compare and upper bound compare
// depends on rilu_pkg
module rilu_scan_unit import rilu_pkg::*; #(
	parameter int CNT_W = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  scan_ctrl_t          ctrl,
	input  logic [ADDR_W-1:0]   ip_address,
	input  logic [SLOT_W-1:0]   start_idx,
	input  logic [CNT_W-1:0]    limit,
	input  logic [ENTRY_W-1:0]  entry_rdata,
	output logic [CNT_W-1:0]    idx,
	output scan_stat_t          stat,
	output logic                res_found,
	output logic [OFFSET_W-1:0] res_offset,
	output logic [LENGTH_W-1:0] res_length
);

	logic [ADDR_W-1:0]  addr_q;
	logic [CNT_W-1:0]   idx_q;
	logic               pend_q;
	logic [UPPER_W-1:0] upper;

	always_comb begin
		upper         = entry_rdata[ENTRY_W-1 -: UPPER_W];
		stat.in_range = idx_q < limit;
		// entry read last cycle is checked against the address
		stat.hit      = pend_q && (upper >= addr_q);
	end

	assign idx = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (ctrl.load_idx) begin
			pend_q <= 1'b0;
		end else if (ctrl.step) begin
			pend_q <= stat.in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_addr) begin
			addr_q <= ip_address;
		end
		if (ctrl.load_idx) begin
			idx_q <= CNT_W'(start_idx);
		end else if (ctrl.step && stat.in_range) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (ctrl.capture) begin
			res_found  <= stat.hit;
			res_offset <= stat.hit ? entry_rdata[LENGTH_W +: OFFSET_W] : '0;
			res_length <= stat.hit ? entry_rdata[LENGTH_W-1:0] : '0;
		end
	end

endmodule

@@ hdl/ipv4_range_table_lookup_unit.sv @@
// ipv4 range table lookup unit: prefix start table, sorted range table, scan sequencer
// write items are written on accept; a lookup goes through the prefix read, the scan of the
// entries and the done state, which waits for the output register, before the next accept
// the scan reads one range entry per cycle through the single read port of the entry ram
// arst_n clears the sequencer, the output valid flag and entry_limit (0); table contents
// are undefined until written
module ipv4_range_table_lookup_unit import rilu_pkg::*; #(
	parameter int MAX_ENTRIES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration: entry_limit
	input  logic                cfg_we,
	input  logic [LIMIT_W-1:0]  cfg_wdata,
	// input items
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [SLOT_W-1:0]   prefix_start_value,
	input  logic [UPPER_W-1:0]  entry_upper,
	input  logic [OFFSET_W-1:0] entry_offset,
	input  logic [LENGTH_W-1:0] entry_length,
	input  logic [ADDR_W-1:0]   ip_address,
	// result items
	output logic                out_valid,
	input  logic                out_ready,
	output logic                found,
	output logic [OFFSET_W-1:0] record_offset,
	output logic [LENGTH_W-1:0] record_length
);

	// entry index width and counter width (counter also holds the limit itself)
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = ($clog2(MAX_ENTRIES + 1) > LIMIT_W) ?
		$clog2(MAX_ENTRIES + 1) : LIMIT_W;

	state_t              state_q, state_d;
	logic [LIMIT_W-1:0]  entry_limit_q;
	logic [CNT_W-1:0]    limit_eff;
	logic                accept;
	logic                is_lookup;
	logic                pfx_we, pfx_re;
	logic                ent_we, ent_re;
	logic [SLOT_W-1:0]   pfx_rdata;
	logic [ENTRY_W-1:0]  ent_rdata;
	scan_ctrl_t          scan_ctrl;
	scan_stat_t          scan_stat;
	logic [CNT_W-1:0]    scan_idx;
	logic                res_found;
	logic [OFFSET_W-1:0] res_offset;
	logic [LENGTH_W-1:0] res_length;
	logic                out_load;
	logic                out_valid_q;
	logic                found_q;
	logic [OFFSET_W-1:0] record_offset_q;
	logic [LENGTH_W-1:0] record_length_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_limit_q <= '0;
		end else if (cfg_we) begin
			entry_limit_q <= cfg_wdata;
		end
	end

	// a limit beyond the table size stops at the table size
	assign limit_eff = (CNT_W'(entry_limit_q) > CNT_W'(MAX_ENTRIES)) ?
		CNT_W'(MAX_ENTRIES) : CNT_W'(entry_limit_q);

	// handshake and table write decode
	assign accept    = in_valid && in_ready;
	assign is_lookup = opcode == OP_LOOKUP;

	always_comb begin
		pfx_we = 1'b0;
		ent_we = 1'b0;
		if (accept) begin
			unique case (opcode)
				OP_WRITE_PREFIX: pfx_we = slot < SLOT_W'(PREFIX_COUNT);
				// out-of-range slots are dropped
				OP_WRITE_ENTRY:  ent_we = CNT_W'(slot) < CNT_W'(MAX_ENTRIES);
				default: begin
					pfx_we = 1'b0;
					ent_we = 1'b0;
				end
			endcase
		end
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && is_lookup) state_d = ST_PFX;
			ST_PFX:  state_d = ST_SCAN;
			ST_SCAN: if (scan_ctrl.capture) state_d = ST_DONE;
			ST_DONE: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_ready            = state_q == ST_IDLE;
		pfx_re              = accept && is_lookup;
		scan_ctrl.load_addr = accept && is_lookup;
		// prefix ram data is valid in the cycle after the lookup is taken
		scan_ctrl.load_idx  = state_q == ST_PFX;
		scan_ctrl.step      = state_q == ST_SCAN;
		// stop on the first covering entry or when the index reaches the limit
		scan_ctrl.capture   = (state_q == ST_SCAN) && (scan_stat.hit || !scan_stat.in_range);
		ent_re              = state_q == ST_SCAN;
		out_load            = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// prefix start table, one entry per first octet
	rilu_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (PREFIX_COUNT)
	) u_pfx_ram (
		.clk   (clk),
		.we    (pfx_we),
		.waddr (slot[PREFIX_AW-1:0]),
		.wdata (prefix_start_value),
		.re    (pfx_re),
		.raddr (ip_address[ADDR_W-1 -: PREFIX_AW]),
		.rdata (pfx_rdata)
	);

	// range entry table: {upper, offset, length}
	rilu_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (IDX_W'(slot)),
		.wdata ({entry_upper, entry_offset, entry_length}),
		.re    (ent_re),
		.raddr (IDX_W'(scan_idx)),
		.rdata (ent_rdata)
	);

	// index counter and compare unit
	rilu_scan_unit #(
		.CNT_W (CNT_W)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (scan_ctrl),
		.ip_address  (ip_address),
		.start_idx   (pfx_rdata),
		.limit       (limit_eff),
		.entry_rdata (ent_rdata),
		.idx         (scan_idx),
		.stat        (scan_stat),
		.res_found   (res_found),
		.res_offset  (res_offset),
		.res_length  (res_length)
	);

	// output register, frees the sequencer as soon as the result is parked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found_q         <= res_found;
			record_offset_q <= res_offset;
			record_length_q <= res_length;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign record_offset = record_offset_q;
	assign record_length = record_length_q;

`ifndef NO_ASSERTIONS
	a_lookup_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_lookup) |=> (state_q == ST_PFX))
		else $error("lookup item did not start the prefix read");

	a_scan_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_stat.in_range) |=>
		(scan_idx == $past(scan_idx) + CNT_W'(1)))
		else $error("scan index did not advance by one");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result item raised outside the done state");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (record_offset_q == '0 && record_length_q == '0))
		else $error("miss result carries a nonzero record");
`endif

endmodule

@@ bench/testbench.sv @@
// self-checking bench for ipv4_range_table_lookup_unit: table writes, range scans, limit settings
// depends on rilu_pkg and the unit's rtl; every lookup result is checked against an in-bench scan
module testbench;
	import rilu_pkg::*;

	localparam int unsigned ENTRY_COUNT  = 65536;
	localparam int          TABLE_SIZE   = 48;   // entries of the well-formed range table
	localparam int          DRAIN_CYCLES = 16;   // writes give no result to wait for, lookups are counted
	localparam int          LONG_HOLD    = 200;
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [SLOT_W-1:0]   slot;
		logic [SLOT_W-1:0]   start_value;
		logic [UPPER_W-1:0]  upper;
		logic [OFFSET_W-1:0] offset;
		logic [LENGTH_W-1:0] length;
		logic [ADDR_W-1:0]   addr;
	} request_t;

	typedef struct packed {
		logic                hit;
		logic [OFFSET_W-1:0] offset;
		logic [LENGTH_W-1:0] length;
	} match_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [LIMIT_W-1:0]  cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OPCODE_W-1:0] opcode = '0;
	logic [SLOT_W-1:0]   slot = '0;
	logic [SLOT_W-1:0]   prefix_start_value = '0;
	logic [UPPER_W-1:0]  entry_upper = '0;
	logic [OFFSET_W-1:0] entry_offset = '0;
	logic [LENGTH_W-1:0] entry_length = '0;
	logic [ADDR_W-1:0]   ip_address = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                found;
	logic [OFFSET_W-1:0] record_offset;
	logic [LENGTH_W-1:0] record_length;

	// shadow copy of the unit's tables and limit register
	logic [LIMIT_W-1:0]  limit_reg = '0;
	logic [SLOT_W-1:0]   prefix_mem [PREFIX_COUNT];
	bit                  prefix_valid [PREFIX_COUNT];
	logic [UPPER_W-1:0]  upper_mem [ENTRY_COUNT];
	logic [OFFSET_W-1:0] offset_mem [ENTRY_COUNT];
	logic [LENGTH_W-1:0] length_mem [ENTRY_COUNT];
	bit                  entry_valid [ENTRY_COUNT];
	logic [7:0]          known_octets [$];
	int unsigned         entry_band = 32'hFFFF_FFFF / TABLE_SIZE;

	match_t              match_queue [$];
	match_t              want_result;
	int                  mismatch_count = 0;

	// idle control for both sides
	int                  in_gap_max = 10;
	int                  out_gap_max = 10;
	int                  ready_stall = 0;
	int                  hold_request = 0;

	ipv4_range_table_lookup_unit #(
		.MAX_ENTRIES(ENTRY_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.slot(slot),
		.prefix_start_value(prefix_start_value),
		.entry_upper(entry_upper),
		.entry_offset(entry_offset),
		.entry_length(entry_length),
		.ip_address(ip_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.record_offset(record_offset),
		.record_length(record_length)
	);

	always #1 clk = ~clk;

	function automatic int draw_idle(input int max_gap);
		return int'($urandom_range(0, max_gap));
	endfunction

	// scan from the octet's start entry; returns 0 on an unwritten octet prefix or scanned slot
	function automatic bit scan_range_table(input logic [ADDR_W-1:0] addr, output match_t res);
		int unsigned idx;
		int unsigned stop;
		res = '0;
		if (!prefix_valid[addr[31:24]])
			return 1'b0;
		// limits above the table size behave as the table size
		stop = (limit_reg > 17'(ENTRY_COUNT)) ? ENTRY_COUNT : {15'd0, limit_reg};
		for (idx = {16'd0, prefix_mem[addr[31:24]]}; idx < stop; idx++) begin
			if (!entry_valid[idx])
				return 1'b0;
			if (upper_mem[idx] >= addr) begin
				res.hit = 1'b1;
				res.offset = offset_mem[idx];
				res.length = length_mem[idx];
				return 1'b1;
			end
		end
		return 1'b1;
	endfunction

	// first entry of the well-formed table that covers the octet's lowest address
	function automatic logic [SLOT_W-1:0] cover_start(input logic [7:0] octet);
		for (int i = 0; i < TABLE_SIZE; i++)
			if (upper_mem[i] >= {octet, 24'd0})
				return 16'(i);
		return 16'(TABLE_SIZE - 1);
	endfunction

	function automatic request_t random_fields();
		request_t r;
		r.op = OP_UNUSED;
		r.slot = 16'($urandom);
		r.start_value = 16'($urandom);
		r.upper = $urandom;
		r.offset = 24'($urandom);
		r.length = 8'($urandom);
		r.addr = $urandom;
		return r;
	endfunction

	function automatic request_t prefix_req(input logic [SLOT_W-1:0] s, input logic [SLOT_W-1:0] v);
		request_t r;
		r = random_fields();
		r.op = OP_WRITE_PREFIX;
		r.slot = s;
		r.start_value = v;
		return r;
	endfunction

	function automatic request_t entry_req(input logic [SLOT_W-1:0] s, input logic [UPPER_W-1:0] u,
			input logic [OFFSET_W-1:0] o, input logic [LENGTH_W-1:0] l);
		request_t r;
		r = random_fields();
		r.op = OP_WRITE_ENTRY;
		r.slot = s;
		r.upper = u;
		r.offset = o;
		r.length = l;
		return r;
	endfunction

	function automatic request_t lookup_req(input logic [ADDR_W-1:0] a);
		request_t r;
		r = random_fields();
		r.op = OP_LOOKUP;
		r.addr = a;
		return r;
	endfunction

	// address whose scan stays on written entries: a known octet, a bound +-1, or anything
	function automatic bit pick_lookup_addr(output logic [ADDR_W-1:0] addr);
		match_t      probe;
		int unsigned pick;
		int unsigned i;
		bit          ok;
		ok = 1'b0;
		addr = '0;
		for (int tries = 0; tries < 16 && !ok; tries++) begin
			pick = $urandom_range(0, 9);
			if (pick < 4 && known_octets.size() > 0)
				addr = {known_octets[$urandom_range(0, known_octets.size() - 1)], 24'($urandom)};
			else if (pick < 7) begin
				i = $urandom_range(0, TABLE_SIZE - 1);
				addr = upper_mem[i] + 32'($urandom_range(0, 2)) - 32'd1;
			end else
				addr = $urandom;
			ok = scan_range_table(addr, probe);
		end
		return ok;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// offer one item after a drawn gap, hold it until accepted, then update the shadow tables
	task automatic send_item(input request_t req);
		int     gap;
		match_t res;
		gap = draw_idle(in_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= req.op;
		slot <= req.slot;
		prefix_start_value <= req.start_value;
		entry_upper <= req.upper;
		entry_offset <= req.offset;
		entry_length <= req.length;
		ip_address <= req.addr;
		do @(posedge clk); while (!in_ready);
		case (req.op)
			OP_WRITE_PREFIX: begin
				// slots past the prefix table are dropped by the unit
				if (req.slot < PREFIX_COUNT) begin
					prefix_mem[req.slot[7:0]] = req.start_value;
					prefix_valid[req.slot[7:0]] = 1'b1;
					known_octets.push_back(req.slot[7:0]);
				end
			end
			OP_WRITE_ENTRY: begin
				upper_mem[req.slot] = req.upper;
				offset_mem[req.slot] = req.offset;
				length_mem[req.slot] = req.length;
				entry_valid[req.slot] = 1'b1;
			end
			OP_LOOKUP: begin
				void'(scan_range_table(req.addr, res));
				match_queue.push_back(res);
			end
			default: begin
			end
		endcase
	endtask

	// drop valid, wait out every pending result, then give trailing writes time to land
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (match_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		settle_block();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		limit_reg = value;
	endtask

	// limit zero: every scan starts at or above the limit and misses
	task automatic test_empty_limit();
		write_limit('0);
		send_item(prefix_req(16'h0000, 16'h0000));
		send_item(prefix_req(16'h00FF, 16'hFFFF));
		send_item(lookup_req(32'h0000_0000));
		send_item(lookup_req(32'hFFFF_FFFF));
	endtask

	// four-entry table: exact bounds, scan stepping, ignored items, limit cutting the scan
	task automatic test_basic_scan();
		write_limit(17'd4);
		send_item(entry_req(16'd0, 32'h0000_0000, 24'h00_0001, 8'h01));
		send_item(entry_req(16'd1, 32'h8000_0000, 24'hFF_FFFF, 8'hFF));
		send_item(entry_req(16'd2, 32'hFFFF_FFFE, 24'h12_3456, 8'h80));
		send_item(entry_req(16'd3, 32'hFFFF_FFFF, 24'h00_0000, 8'h00));
		send_item(prefix_req(16'h0080, 16'd1));
		send_item(prefix_req(16'h00FF, 16'd3));
		send_item(lookup_req(32'h0000_0000));
		send_item(lookup_req(32'h0000_0001));
		send_item(lookup_req(32'h8000_0001));
		send_item(lookup_req(32'hFFFF_FFFF));
		// unused opcode and an out-of-range prefix slot must leave the tables alone
		send_item(random_fields());
		send_item(prefix_req(16'h0180, 16'hFFFF));
		send_item(lookup_req(32'h8000_0000));
		write_limit(17'd2);
		send_item(lookup_req(32'h8000_0001));
		send_item(lookup_req(32'hFFFF_FFFF));
	endtask

	// limit above the table size: the scan ends after the last entry
	task automatic test_limit_clamp();
		write_limit(17'h1FFFF);
		send_item(entry_req(16'hFFFF, 32'h0000_0000, 24'h00_0000, 8'h00));
		send_item(prefix_req(16'h00FF, 16'hFFFF));
		send_item(lookup_req(32'hFF00_0000));
		send_item(entry_req(16'hFFFF, 32'hFFFF_FFFF, 24'hAB_CDEF, 8'h5A));
		send_item(lookup_req(32'hFFFF_FFFF));
	endtask

	// sorted table with one band of addresses per entry, last entry covers everything
	task automatic test_table_load();
		logic [ADDR_W-1:0] addr;
		logic [7:0]        octet;
		write_limit(17'(TABLE_SIZE));
		for (int i = 0; i < TABLE_SIZE; i++)
			send_item(entry_req(16'(i), (i == TABLE_SIZE - 1) ? 32'hFFFF_FFFF :
				32'(i) * entry_band + $urandom_range(0, entry_band - 1), 24'($urandom), 8'($urandom)));
		send_item(prefix_req(16'h0000, cover_start(8'h00)));
		send_item(prefix_req(16'h00FF, cover_start(8'hFF)));
		repeat (24) begin
			octet = 8'($urandom);
			send_item(prefix_req({8'd0, octet}, cover_start(octet)));
		end
		repeat (10)
			if (pick_lookup_addr(addr))
				send_item(lookup_req(addr));
	endtask

	// receiver holds off while lookups keep coming, so the unit fills and drops in_ready
	task automatic test_backpressure();
		logic [ADDR_W-1:0] addr;
		in_gap_max = 0;
		out_gap_max = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		hold_request = LONG_HOLD;
		repeat (30)
			if (pick_lookup_addr(addr))
				send_item(lookup_req(addr));
	endtask

	// mostly lookups on the well-formed table, with band-keeping rewrites and some noise
	task automatic test_random_traffic(input logic [LIMIT_W-1:0] limit, input int in_max,
			input int out_max, input int count);
		logic [ADDR_W-1:0] addr;
		logic [7:0]        octet;
		int unsigned       roll;
		int unsigned       i;
		write_limit(limit);
		in_gap_max = in_max;
		out_gap_max = out_max;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < 60 && pick_lookup_addr(addr))
				send_item(lookup_req(addr));
			else if (roll < 80) begin
				if ($urandom_range(0, 3) != 0) begin
					// stay inside the entry's band so the table remains sorted
					i = $urandom_range(0, TABLE_SIZE - 2);
					send_item(entry_req(16'(i), i * entry_band + $urandom_range(0, entry_band - 1),
						24'($urandom), 8'($urandom)));
				end else
					send_item(entry_req(16'($urandom_range(TABLE_SIZE, 65535)), $urandom,
						24'($urandom), 8'($urandom)));
			end else if (roll < 92) begin
				if ($urandom_range(0, 3) != 0) begin
					octet = 8'($urandom);
					send_item(prefix_req({8'd0, octet}, cover_start(octet)));
				end else
					send_item(prefix_req(16'($urandom), 16'($urandom)));
			end else
				send_item(random_fields());
		end
	endtask

	// result side: long hold when asked, otherwise the stall drawn per result item
	initial begin : ready_driver
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				out_ready <= 1'b0;
				repeat (hold_request - 1) @(negedge clk);
				hold_request = 0;
			end else if (ready_stall > 0) begin
				out_ready <= 1'b0;
				ready_stall--;
			end else
				out_ready <= 1'b1;
		end
	end

	// compare each accepted result item with the oldest predicted match
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (match_queue.size() == 0)
				flag_mismatch("result item with no lookup pending");
			else begin
				want_result = match_queue.pop_front();
				if (found !== want_result.hit)
					flag_mismatch($sformatf("found %0b, want %0b", found, want_result.hit));
				if (record_offset !== want_result.offset)
					flag_mismatch($sformatf("record_offset %h, want %h", record_offset,
						want_result.offset));
				if (record_length !== want_result.length)
					flag_mismatch($sformatf("record_length %h, want %h", record_length,
						want_result.length));
			end
			ready_stall = draw_idle(out_gap_max);
		end
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_empty_limit();
		test_basic_scan();
		test_limit_clamp();
		test_table_load();
		test_backpressure();
		test_random_traffic(17'd48, 10, 10, 75);
		test_random_traffic(17'd24, 0, 0, 75);
		test_random_traffic(17'd1, 10, 0, 75);
		test_random_traffic(17'd65535, 0, 10, 75);
		test_random_traffic(17'h10000, 10, 10, 75);
		test_random_traffic(17'h1FFFF, 0, 0, 75);
		test_random_traffic(17'($urandom_range(0, 131071)), 10, 10, 75);
		settle_block();
		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// far beyond the slowest correct run
	initial begin : watchdog
		#1200000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/rilu_pkg.sv
hdl/rilu_ram.sv
hdl/rilu_scan_unit.sv
hdl/ipv4_range_table_lookup_unit.sv
bench/testbench.sv
